// ===== rtl/textured_wall_column_renderer_assert.svh =====
// ----------------------------------------------------------------------------
// Textured wall column renderer assertion macros
// Property shorthands used by the renderer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TEXTURED_WALL_COLUMN_RENDERER_ASSERT_SVH
`define TEXTURED_WALL_COLUMN_RENDERER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TWCR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("renderer check failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define TWCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("renderer check failed: next-cycle implication");

`endif

// ===== rtl/twcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Textured wall column renderer package
// Screen and texture geometry, payload types, codes and sequencer states.
// ----------------------------------------------------------------------------
package twcr_pkg;

   localparam int SCREEN_WIDTH   = 1024;
   localparam int SCREEN_HEIGHT  = 512;
   localparam int TEXTURE_SIZE   = 64;

   localparam int TEX_BITS       = $clog2(TEXTURE_SIZE);
   localparam int TEX_AREA_BITS  = 2 * TEX_BITS;
   localparam int TEX_COUNT      = 4;
   localparam int MEM_DEPTH      = TEX_COUNT * TEXTURE_SIZE * TEXTURE_SIZE;
   localparam int MEM_AW         = $clog2(MEM_DEPTH);
   localparam int STEP_W         = $clog2(TEX_BITS);

   localparam int COLOR_W        = 32;
   localparam int ADDR_W         = 12;
   localparam int COLUMN_W       = 10;
   localparam int ROW_W          = 9;
   localparam int HEIGHT_W       = 12;
   localparam int SIDE_W         = 3;
   localparam int FRAC_W         = 6;
   localparam int DIST_W         = 26;

   localparam logic       CMD_LOAD    = 1'b0;
   localparam logic       CMD_DRAW    = 1'b1;
   localparam logic [2:0] SIDE_NONE   = 3'd4;
   localparam logic       CSR_CEILING = 1'b0;
   localparam logic       CSR_FLOOR   = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [1:0]          texture_pick;
      logic [ADDR_W-1:0]   texel_address;
      logic [COLOR_W-1:0]  texel_value;
      logic [COLUMN_W-1:0] screen_column;
      logic [ROW_W-1:0]    screen_row;
      logic [HEIGHT_W-1:0] column_height;
      logic [SIDE_W-1:0]   hit_side;
      logic [FRAC_W-1:0]   hit_fraction;
   } req_payload_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_color;
      logic               column_done;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_READ,
      ST_FETCH,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/textured_wall_column_renderer.sv =====
// ----------------------------------------------------------------------------
// Textured wall column renderer
// A texel load writes the texture RAM at acceptance. A pixel draw outside
// the wall segment or with no hit side goes from PREP straight to OUT; a
// textured wall pixel also passes DIV, READ and FETCH: the texel row is a
// 6-bit quotient made by a restoring divider one bit per cycle, followed by
// a registered texture RAM read. A finished pixel sits in an output
// register, so the next transaction is taken while it waits.
// ----------------------------------------------------------------------------
module textured_wall_column_renderer
   import twcr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [31:0]     csr_data
);

   state_type state_ff, state_in;

   logic [COLOR_W-1:0]  ceiling_ff, floor_ff;
   logic [HEIGHT_W-1:0] count_ff, count_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic [COLUMN_W-1:0] column_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [SIDE_W-1:0]   side_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic [HEIGHT_W-1:0] rem_ff, rem_in;
   logic [TEX_BITS-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic                req_take;
   logic                load_take;
   logic                rd_en;
   logic [MEM_AW-1:0]   wr_addr, rd_addr;
   logic [COLOR_W-1:0]  rd_data;

   logic [HEIGHT_W-1:0]   init_count, count_eff;
   logic [COLOR_W-1:0]    color_eff;
   logic signed [DIST_W-1:0] diff_s, prod_s, start_s, pos_s;
   logic                  wall_hit;
   logic [HEIGHT_W:0]     rem_dbl;
   logic                  rem_ge;

   assign req_take  = req_valid && !req_stall;
   assign load_take = req_take && (req_payload.cmd == CMD_LOAD);
   assign wr_addr   = {req_payload.texture_pick, req_payload.texel_address[TEX_AREA_BITS-1:0]};
   assign rd_addr   = {side_ff[1:0], quot_ff, frac_ff};
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   twcr_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MEM_DEPTH)
   ) u_tex_ram (
      .clock   (clock),
      .wr_en   (load_take),
      .wr_addr (wr_addr),
      .wr_data (req_payload.texel_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // column start and wall segment test
   always_comb begin
      if (height_ff > HEIGHT_W'(SCREEN_HEIGHT)) begin
         init_count = (height_ff - HEIGHT_W'(SCREEN_HEIGHT)) >> 1;
      end else begin
         init_count = '0;
      end
      count_eff = (row_ff == '0) ? init_count : count_ff;
      color_eff = (row_ff == '0) ? ceiling_ff : color_ff;
      diff_s    = DIST_W'(SCREEN_HEIGHT) - DIST_W'(height_ff);
      prod_s    = diff_s * DIST_W'(SCREEN_WIDTH);
      start_s   = (prod_s + ((prod_s < 0) ? DIST_W'(1) : DIST_W'(0))) >>> 1;
      pos_s     = DIST_W'(column_ff) + DIST_W'(row_ff) * DIST_W'(SCREEN_WIDTH);
      wall_hit  = (pos_s >= start_s) && (count_eff < height_ff);
      rem_dbl   = {rem_ff, 1'b0};
      rem_ge    = rem_dbl >= {1'b0, height_ff};
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      color_in     = color_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_stall    = (state_ff != ST_IDLE);
      rd_en        = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_payload.cmd == CMD_DRAW)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            count_in = count_eff;
            color_in = color_eff;
            if (wall_hit) begin
               count_in = count_eff + 1'b1;
               if (side_ff >= SIDE_NONE) begin
                  color_in = '0;
                  state_in = ST_OUT;
               end else begin
                  rem_in   = count_eff;
                  quot_in  = '0;
                  step_in  = STEP_W'(TEX_BITS - 1);
                  state_in = ST_DIV;
               end
            end else begin
               if (count_eff == height_ff) begin
                  color_in = floor_ff;
               end
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            rem_in  = rem_ge ? HEIGHT_W'(rem_dbl - {1'b0, height_ff}) : rem_dbl[HEIGHT_W-1:0];
            quot_in = {quot_ff[TEX_BITS-2:0], rem_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            color_in = rd_data;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.pixel_color = color_ff;
               rsp_in.column_done = (row_ff == ROW_W'(SCREEN_HEIGHT - 1));
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         color_ff     <= '0;
         ceiling_ff   <= '0;
         floor_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         color_ff     <= color_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CEILING) begin
               ceiling_ff <= csr_data;
            end
            if (csr_index == CSR_FLOOR) begin
               floor_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      if (req_take) begin
         column_ff <= req_payload.screen_column;
         row_ff    <= req_payload.screen_row;
         height_ff <= req_payload.column_height;
         side_ff   <= req_payload.hit_side;
         frac_ff   <= req_payload.hit_fraction;
      end
   end

`include "textured_wall_column_renderer_assert.svh"

   `TWCR_ASSERT_SAME(a_busy_stalls, clock, reset, state_ff != ST_IDLE, req_stall)
   `TWCR_ASSERT_SAME(a_read_side_valid, clock, reset, state_ff == ST_READ, side_ff < SIDE_NONE)
   `TWCR_ASSERT_SAME(a_rem_below_height, clock, reset, state_ff == ST_DIV, rem_ff < height_ff)
   `TWCR_ASSERT_NEXT(a_out_leaves, clock, reset, state_ff == ST_OUT && !rsp_stall, rsp_valid)

endmodule

// ===== rtl/twcr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module twcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
